>>> design/wicc_pkg.sv
// wicc_pkg: shared sizes, types and codes for the interval coverage count unit.
// No dependencies; imported by every design file but wicc_ram.
package wicc_pkg;

    localparam int MAX_LENGTH    = 4096;
    localparam int MAX_INTERVALS = 256;

    localparam int POS_W   = 13;                          // start/end/line_length fields
    localparam int WGT_W   = 16;
    localparam int THR_W   = 24;
    localparam int CNT_W   = 13;                          // quiet_count field
    localparam int ADDR_W  = $clog2(MAX_LENGTH);
    localparam int LEN_W   = $clog2(MAX_LENGTH + 1);      // holds MAX_LENGTH itself
    localparam int TALLY_W = $clog2(MAX_INTERVALS + 1);
    localparam int STORE_W = 25;                          // one weight change entry
    localparam int SUM_W   = STORE_W + 1;                 // running sum, signed

    localparam int S_DATA_W = 48;                         // 13+13+16 rounded to bytes
    localparam int M_DATA_W = 16;                         // 13+1 rounded to bytes

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 24;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LINE_LENGTH = 1'b0,
        REG_THRESHOLD   = 1'b1
    } cfg_reg_t;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } alu_op_t;

    typedef enum logic [2:0] {
        ST_CLEAR,       // post-reset zeroing of the change store
        ST_IDLE,
        ST_RD_S,
        ST_WR_S,
        ST_RD_E,
        ST_WR_E,
        ST_SWEEP,
        ST_OUT
    } state_t;

    // Shared adder/comparator controls
    typedef struct packed {
        alu_op_t                  op;
        logic signed [SUM_W-1:0]  a;
        logic signed [SUM_W-1:0]  b;
    } alu_req_t;

    typedef struct packed {
        logic signed [SUM_W-1:0]  sum;
        logic                     below;  // sum < threshold
    } alu_rsp_t;

endpackage

>>> design/weighted_interval_coverage_count_unit.sv
// weighted_interval_coverage_count_unit: top level, sequencer and registers.
// Depends on wicc_pkg, wicc_ram and wicc_addcmp.
//
// Usage
//   s_ channel: one interval per word (start, end, weight); tlast marks the
//   final interval of a set. m_ channel: one word per set, carrying the count
//   of positions whose summed weight is below threshold plus the overflow flag.
//   cfg_ channel: register writes (0 line_length, 1 threshold), always ready;
//   write only while the unit is idle.
// Operation
//   Intervals are kept as +w / -w changes in a 4096-entry RAM; each change is
//   a read-modify-write (RD_ then WR_ state) through the single shared adder.
//   A word with both changes steps IDLE, RD_S, WR_S, RD_E, WR_E; one with only
//   the start change IDLE, RD_S, WR_S; an ignored word is taken in IDLE. After
//   the tlast word a sweep walks the whole RAM, summing and zeroing it, then
//   ST_OUT loads the result register. s_tready is low throughout.
// Reset
//   aresetn (sync, low) starts a clearing pass over the MAX_LENGTH = 4096 entries,
//   writing zero to the RAM; no word is taken until it completes.
// Stall
//   The result sits in an output register, so the next set may be taken while
//   it waits; a second result holds the unit at end of sweep until m_tready.
module weighted_interval_coverage_count_unit (
    input  logic                               aclk,
    input  logic                               aresetn,

    input  logic                               s_tvalid,
    output logic                               s_tready,
    // [12:0] interval_start, [25:13] interval_end, [41:26] weight, rest zero
    input  logic [wicc_pkg::S_DATA_W-1:0]      s_tdata,
    input  logic                               s_tlast,

    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [12:0] quiet_count, [13] overflow, rest zero
    output logic [wicc_pkg::M_DATA_W-1:0]      m_tdata,

    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [wicc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [wicc_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import wicc_pkg::*;

    // configuration
    logic [POS_W-1:0]  line_length_reg;
    logic [THR_W-1:0]  threshold_reg;

    // sequencer
    state_t            state_reg, state_next;
    logic [LEN_W-1:0]  cnt_reg, cnt_next;

    // per-set state
    logic [TALLY_W-1:0] tally_reg, tally_next;
    logic               ovf_reg, ovf_next;

    // current interval, already clipped
    logic [ADDR_W-1:0]  s_idx_reg, s_idx_next;
    logic [ADDR_W-1:0]  e_idx_reg, e_idx_next;
    logic               e_ok_reg, e_ok_next;      // end change lies inside the store
    logic [WGT_W-1:0]   w_reg, w_next;
    logic               last_reg, last_next;

    // sweep accumulators
    logic signed [SUM_W-1:0] acc_reg, acc_next;
    logic [CNT_W-1:0]        quiet_reg, quiet_next;

    // result register
    logic                m_valid_reg, m_valid_next;
    logic [CNT_W-1:0]    m_quiet_reg, m_quiet_next;
    logic                m_ovf_reg, m_ovf_next;

    // RAM and ALU wiring
    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr, ram_raddr;
    logic [STORE_W-1:0]  ram_wdata, ram_rdata;
    logic signed [SUM_W-1:0] rdata_ext, w_ext;
    alu_req_t            alu_req;
    alu_rsp_t            alu_rsp;

    // input decode
    logic [POS_W-1:0]  in_start, in_end, s_eff, e_eff;
    logic [WGT_W-1:0]  in_weight;
    logic [LEN_W-1:0]  eff_len;
    logic              accept, room, adds;
    logic              sweep_data, out_free;

    assign in_start  = s_tdata[POS_W-1:0];
    assign in_end    = s_tdata[2*POS_W-1:POS_W];
    assign in_weight = s_tdata[2*POS_W+WGT_W-1:2*POS_W];

    assign eff_len = (LEN_W'(line_length_reg) > LEN_W'(MAX_LENGTH))
                   ? LEN_W'(MAX_LENGTH) : LEN_W'(line_length_reg);

    // start of zero means position 1; end clipped to the line
    assign s_eff = (in_start == '0) ? POS_W'(1) : in_start;
    assign e_eff = (LEN_W'(in_end) > eff_len) ? POS_W'(eff_len) : in_end;
    assign room  = (tally_reg < TALLY_W'(MAX_INTERVALS));
    assign adds  = room && (LEN_W'(s_eff) <= eff_len) && (s_eff <= e_eff);

    assign accept     = s_tvalid && s_tready;
    assign sweep_data = (cnt_reg != '0);          // read data of cnt-1 arrives now
    assign out_free   = !m_valid_reg || m_tready;

    assign rdata_ext = $signed({{(SUM_W - STORE_W){ram_rdata[STORE_W-1]}}, ram_rdata});
    assign w_ext     = $signed({{(SUM_W - WGT_W){1'b0}}, w_reg});

    wicc_ram #(
        .WIDTH (STORE_W),
        .DEPTH (MAX_LENGTH)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    wicc_addcmp u_alu (
        .req       (alu_req),
        .threshold (threshold_reg),
        .rsp       (alu_rsp)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (cnt_reg == LEN_W'(MAX_LENGTH - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    if (adds) begin
                        state_next = ST_RD_S;
                    end else if (s_tlast) begin
                        state_next = ST_SWEEP;
                    end
                end
            end
            ST_RD_S: state_next = ST_WR_S;
            ST_WR_S: begin
                if (e_ok_reg) begin
                    state_next = ST_RD_E;
                end else if (last_reg) begin
                    state_next = ST_SWEEP;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_RD_E: state_next = ST_WR_E;
            ST_WR_E: state_next = last_reg ? ST_SWEEP : ST_IDLE;
            ST_SWEEP: begin
                if (cnt_reg == LEN_W'(MAX_LENGTH)) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    // sequencer outputs: RAM ports, ALU operands, ready
    always_comb begin
        s_tready   = 1'b0;
        ram_we     = 1'b0;
        ram_waddr  = cnt_reg[ADDR_W-1:0];
        ram_wdata  = '0;
        ram_raddr  = cnt_reg[ADDR_W-1:0];
        alu_req.op = ALU_ADD;
        alu_req.a  = rdata_ext;
        alu_req.b  = w_ext;
        unique case (state_reg)
            ST_CLEAR: begin
                ram_we = 1'b1;
            end
            ST_IDLE: begin
                s_tready = 1'b1;
            end
            ST_RD_S: begin
                ram_raddr = s_idx_reg;
            end
            ST_WR_S: begin
                ram_we    = 1'b1;
                ram_waddr = s_idx_reg;
                ram_wdata = alu_rsp.sum[STORE_W-1:0];
            end
            ST_RD_E: begin
                ram_raddr = e_idx_reg;
            end
            ST_WR_E: begin
                alu_req.op = ALU_SUB;
                ram_we     = 1'b1;
                ram_waddr  = e_idx_reg;
                ram_wdata  = alu_rsp.sum[STORE_W-1:0];
            end
            ST_SWEEP: begin
                // read and zero entry cnt; old contents come back next cycle
                ram_we    = (cnt_reg != LEN_W'(MAX_LENGTH));
                alu_req.a = acc_reg;
                alu_req.b = rdata_ext;
            end
            ST_OUT: begin
            end
            default: begin
            end
        endcase
    end

    // datapath next values
    always_comb begin
        cnt_next     = '0;
        acc_next     = '0;
        quiet_next   = '0;
        tally_next   = tally_reg;
        ovf_next     = ovf_reg;
        s_idx_next   = s_idx_reg;
        e_idx_next   = e_idx_reg;
        e_ok_next    = e_ok_reg;
        w_next       = w_reg;
        last_next    = last_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_quiet_next = m_quiet_reg;
        m_ovf_next   = m_ovf_reg;

        if (state_reg == ST_CLEAR) begin
            cnt_next = cnt_reg + LEN_W'(1);
        end

        if (accept) begin
            s_idx_next = ADDR_W'(s_eff - POS_W'(1));
            e_idx_next = e_eff[ADDR_W-1:0];
            e_ok_next  = (LEN_W'(e_eff) < LEN_W'(MAX_LENGTH));
            w_next     = in_weight;
            last_next  = s_tlast;
            if (room) begin
                tally_next = tally_reg + TALLY_W'(1);
            end else begin
                ovf_next = 1'b1;
            end
        end

        if (state_reg == ST_SWEEP) begin
            cnt_next   = cnt_reg + LEN_W'(1);
            acc_next   = acc_reg;
            quiet_next = quiet_reg;
            if (sweep_data) begin
                acc_next = alu_rsp.sum;
                // entry cnt-1 lies on the line when cnt <= length
                if (alu_rsp.below && (cnt_reg <= eff_len)) begin
                    quiet_next = quiet_reg + CNT_W'(1);
                end
            end
        end

        if (state_reg == ST_OUT) begin
            acc_next   = acc_reg;
            quiet_next = quiet_reg;
            if (out_free) begin
                m_valid_next = 1'b1;
                m_quiet_next = quiet_reg;
                m_ovf_next   = ovf_reg;
                tally_next   = '0;
                ovf_next     = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_CLEAR;
            cnt_reg         <= '0;
            tally_reg       <= '0;
            ovf_reg         <= 1'b0;
            acc_reg         <= '0;
            quiet_reg       <= '0;
            m_valid_reg     <= 1'b0;
            line_length_reg <= POS_W'(4096);
            threshold_reg   <= THR_W'(1);
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            tally_reg   <= tally_next;
            ovf_reg     <= ovf_next;
            acc_reg     <= acc_next;
            quiet_reg   <= quiet_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_reg_t'(cfg_index))
                    REG_LINE_LENGTH: line_length_reg <= cfg_data[POS_W-1:0];
                    REG_THRESHOLD:   threshold_reg   <= cfg_data[THR_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        s_idx_reg   <= s_idx_next;
        e_idx_reg   <= e_idx_next;
        e_ok_reg    <= e_ok_next;
        w_reg       <= w_next;
        last_reg    <= last_next;
        m_quiet_reg <= m_quiet_next;
        m_ovf_reg   <= m_ovf_next;
    end

    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = {{(M_DATA_W - CNT_W - 1){1'b0}}, m_ovf_reg, m_quiet_reg};

    // no word taken in the cycle after reset: the clearing pass runs first
    a_clear_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !s_tready)
        else $error("input taken before store cleared");

    // tally never passes the interval limit
    a_tally_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        tally_reg <= TALLY_W'(MAX_INTERVALS))
        else $error("interval tally out of range");

    // a new result is only loaded at the end of a sweep
    a_result_after_sweep: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !$past(m_valid_reg && !m_tready)) |-> $past(state_reg == ST_OUT))
        else $error("result without sweep");

endmodule

>>> design/wicc_ram.sv
// wicc_ram: generic simple dual-port RAM, one write and one registered read port.
// Read during write to the same address returns the old contents.
module wicc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> design/wicc_addcmp.sv
// wicc_addcmp: the one shared adder/subtractor with threshold compare.
// Depends on wicc_pkg.
module wicc_addcmp (
    input  wicc_pkg::alu_req_t             req,
    input  logic [wicc_pkg::THR_W-1:0]     threshold,
    output wicc_pkg::alu_rsp_t             rsp
);
    import wicc_pkg::*;

    logic signed [SUM_W-1:0] thr_ext;

    assign thr_ext = $signed({{(SUM_W - THR_W){1'b0}}, threshold});

    always_comb begin
        rsp.sum   = (req.op == ALU_SUB) ? (req.a - req.b) : (req.a + req.b);
        rsp.below = (rsp.sum < thr_ext);
    end

endmodule

>>> sim/wicc_quiet_count_checker.sv
// wicc_quiet_count_checker: watches the interval, result and register channels of the unit,
// predicts each set's quiet count and overflow flag, and compares them with the result words.
// Depends on wicc_pkg.
`timescale 1ns / 100ps
module wicc_quiet_count_checker
    import wicc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [S_DATA_W-1:0]   s_tdata,
    input  logic                  s_tlast,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [M_DATA_W-1:0]   m_tdata,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int unsigned           fail_count,
    output int unsigned           pending
);

    typedef struct packed {
        logic [CNT_W-1:0] quiet_count;
        logic             overflow;
    } quiet_result_t;

    logic [POS_W-1:0] line_len_cfg;
    logic [THR_W-1:0] thresh_cfg;
    longint           change_store [MAX_LENGTH];
    int unsigned      intervals_in_set;
    bit               set_overflowed;
    quiet_result_t    quiet_results_due [$];

    function automatic int unsigned live_length();
        return (line_len_cfg > MAX_LENGTH) ? MAX_LENGTH : int'(line_len_cfg);
    endfunction

    function automatic void clear_set();
        for (int i = 0; i < MAX_LENGTH; i++)
            change_store[i] = 0;
        intervals_in_set = 0;
        set_overflowed   = 1'b0;
    endfunction

    // +w at the first covered position, -w just past the last one
    function automatic void add_interval(int unsigned first, int unsigned stop, longint w);
        int unsigned len;
        len = live_length();
        if (first == 0)
            first = 1;
        if (stop > len)
            stop = len;
        if (first > len || first > stop)
            return;
        change_store[first-1] += w;
        if (stop < MAX_LENGTH)
            change_store[stop] -= w;
    endfunction

    function automatic quiet_result_t sweep_quiet_positions();
        quiet_result_t r;
        longint        run_sum;
        int unsigned   n;
        int unsigned   len;
        run_sum = 0;
        n       = 0;
        len     = live_length();
        for (int i = 0; i < len; i++) begin
            run_sum += change_store[i];
            if (run_sum < longint'(thresh_cfg))
                n++;
        end
        r.quiet_count = n[CNT_W-1:0];
        r.overflow    = set_overflowed;
        return r;
    endfunction

    always @(posedge aclk) begin
        quiet_result_t want;
        quiet_result_t due;
        if (!aresetn) begin
            line_len_cfg = POS_W'(MAX_LENGTH);
            thresh_cfg   = THR_W'(1);
            clear_set();
            quiet_results_due.delete();
            fail_count = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_LINE_LENGTH: line_len_cfg = cfg_data[POS_W-1:0];
                    REG_THRESHOLD:   thresh_cfg   = cfg_data[THR_W-1:0];
                    default: ;
                endcase
            end

            if (m_tvalid && m_tready) begin
                if (quiet_results_due.size() == 0) begin
                    $error("result word 0x%h arrived with no set outstanding", m_tdata);
                    fail_count++;
                end else begin
                    want = quiet_results_due.pop_front();
                    if (m_tdata[CNT_W-1:0] !== want.quiet_count) begin
                        $error("quiet_count: expected %0d, got %0d",
                               want.quiet_count, m_tdata[CNT_W-1:0]);
                        fail_count++;
                    end
                    if (m_tdata[CNT_W] !== want.overflow) begin
                        $error("overflow: expected %0d, got %0d", want.overflow, m_tdata[CNT_W]);
                        fail_count++;
                    end
                    if (m_tdata[M_DATA_W-1:CNT_W+1] !== '0) begin
                        $error("padding: expected 0, got 0x%h", m_tdata[M_DATA_W-1:CNT_W+1]);
                        fail_count++;
                    end
                end
            end

            if (s_tvalid && s_tready) begin
                // a full set drops further intervals but still honours tlast
                if (intervals_in_set >= MAX_INTERVALS) begin
                    set_overflowed = 1'b1;
                end else begin
                    intervals_in_set++;
                    add_interval(32'(s_tdata[POS_W-1:0]), 32'(s_tdata[2*POS_W-1:POS_W]),
                                 longint'(s_tdata[2*POS_W+WGT_W-1:2*POS_W]));
                end
                if (s_tlast) begin
                    due = sweep_quiet_positions();
                    quiet_results_due = {quiet_results_due, due};
                    clear_set();
                end
            end
        end
        pending = quiet_results_due.size();
    end

endmodule

>>> sim/tb_weighted_interval_coverage_count_unit.sv
// tb_weighted_interval_coverage_count_unit: stimulus and verdict for the interval coverage unit.
// Depends on wicc_pkg, weighted_interval_coverage_count_unit and wicc_quiet_count_checker.
`timescale 1ns / 100ps
module tb_weighted_interval_coverage_count_unit;
    import wicc_pkg::*;

    localparam int ITEM_TARGET  = 1050;
    localparam int HOLD_CYCLES  = 12000;   // long receiver hold-off, > two sweeps
    localparam int IDLE_LIMIT   = 50000;   // cycles with no word moving on any channel
    localparam int SETTLE_WAIT  = 16;      // covers the read-modify-write of a word
    localparam int TAIL_WAIT    = 4300;    // one full sweep plus output load, with margin

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata   = '0;
    logic                  s_tlast   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_LINE_LENGTH;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    int unsigned fail_count;
    int unsigned pending;

    // stimulus-side bookkeeping
    int unsigned items_sent  = 0;
    int unsigned sets_sent   = 0;
    int unsigned cfg_writes  = 0;
    int unsigned line_len_set = MAX_LENGTH;  // for shaping intervals only
    int unsigned burst_left  = 0;
    bit          gaps_on     = 1'b0;
    bit          hold_req    = 1'b0;
    int unsigned quiet_cycles = 0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    weighted_interval_coverage_count_unit u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    wicc_quiet_count_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // Watchdog: the sweep and the long hold-off are the longest quiet spells, both far
    // below the limit, so reaching it means the unit has locked up.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == IDLE_LIMIT) begin
            $display("tb_weighted_interval_coverage_count_unit NOT OK");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Receiver: cycles through its own stall patterns; one long hold-off on request,
    // counted here so the sender keeps offering while the unit backs up.
    initial begin
        int unsigned rx_cycle;
        rx_cycle = 0;
        forever begin
            @(negedge aclk);
            rx_cycle++;
            if (hold_req) begin
                m_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_req = 1'b0;
            end
            case ((rx_cycle / 2500) % 4)
                0:       m_tready = 1'b1;
                1:       m_tready = ($urandom_range(0, 1) == 1);
                2:       m_tready = ((rx_cycle % 8) < 3);
                default: m_tready = ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    // One interval word. tvalid stays high from word to word unless a gap is due;
    // gaps come between bursts of random length.
    task automatic send_interval(input logic [POS_W-1:0] first, input logic [POS_W-1:0] stop,
                                 input logic [WGT_W-1:0] w, input logic is_last);
        int unsigned gap;
        gap = 0;
        if (gaps_on) begin
            if (burst_left == 0) begin
                gap        = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                                         : $urandom_range(1, 6);
                burst_left = $urandom_range(1, 20);
            end else begin
                burst_left--;
            end
        end
        @(negedge aclk);
        if (gap != 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tdata  = {{(S_DATA_W - 2*POS_W - WGT_W){1'b0}}, w, stop, first};
        s_tlast  = is_last;
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        items_sent++;
        if (is_last)
            sets_sent++;
    endtask

    // Drop tvalid, wait for every outstanding result, then let an in-flight word finish.
    task automatic settle_idle();
        @(negedge aclk);
        s_tvalid = 1'b0;
        wait (pending == 0);
        repeat (SETTLE_WAIT) @(negedge aclk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_index = idx;
        cfg_data  = val;
        cfg_valid = 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid = 1'b0;
        cfg_writes++;
        if (idx == REG_LINE_LENGTH)
            line_len_set = 32'(val[POS_W-1:0]);
    endtask

    // Mostly short lines so that intervals overlap; the extremes and out-of-range
    // lengths (clamped by the unit) still turn up. Upper bits carry junk at times.
    function automatic logic [CFG_DATA_W-1:0] random_line_length();
        logic [CFG_DATA_W-1:0] v;
        case ($urandom_range(0, 9))
            0:       v = '0;
            1:       v = CFG_DATA_W'(1);
            2:       v = CFG_DATA_W'(MAX_LENGTH);
            3:       v = CFG_DATA_W'($urandom_range(MAX_LENGTH + 1, 8191));
            4:       v = CFG_DATA_W'(8191);
            5:       v = CFG_DATA_W'($urandom_range(65, MAX_LENGTH - 1));
            default: v = CFG_DATA_W'($urandom_range(2, 64));
        endcase
        if ($urandom_range(0, 1) == 1)
            v[CFG_DATA_W-1:POS_W] = (CFG_DATA_W - POS_W)'($urandom());
        return v;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] random_threshold();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return CFG_DATA_W'(1);
            2:       return 24'hFF_FFFF;
            3:       return CFG_DATA_W'($urandom_range(60000, 200000));
            4:       return CFG_DATA_W'($urandom());
            default: return CFG_DATA_W'($urandom_range(1, 40));
        endcase
    endfunction

    // A set of random intervals. With reline set, the line length is rewritten
    // half way through, while the set is still open.
    task automatic send_set(input int unsigned n_items, input bit reline);
        logic [POS_W-1:0] first;
        logic [POS_W-1:0] stop;
        logic [WGT_W-1:0] w;
        int unsigned      span;
        for (int k = 0; k < n_items; k++) begin
            if (reline && k == n_items / 2 && k != 0) begin
                settle_idle();
                write_reg(REG_LINE_LENGTH, random_line_length());
            end
            span = (line_len_set > MAX_LENGTH) ? MAX_LENGTH : line_len_set;
            if (span == 0)
                span = 1;
            case ($urandom_range(0, 9))
                0: begin                                // start of zero
                    first = '0;
                    stop  = POS_W'($urandom_range(0, 8191));
                end
                1: begin                                // anything the fields allow
                    first = POS_W'($urandom_range(0, 8191));
                    stop  = POS_W'($urandom_range(0, 8191));
                end
                2: begin                                // start after end
                    first = POS_W'($urandom_range(2, 8191));
                    stop  = POS_W'($urandom_range(0, first - 1));
                end
                3: begin                                // end at or past the line's end
                    first = POS_W'($urandom_range(1, span));
                    stop  = POS_W'($urandom_range(span, 8191));
                end
                default: begin                          // well-formed, inside the line
                    first = POS_W'($urandom_range(1, span));
                    stop  = POS_W'($urandom_range(first, span));
                end
            endcase
            case ($urandom_range(0, 7))
                0:       w = '0;
                1:       w = 16'hFFFF;
                2, 3:    w = WGT_W'($urandom_range(1, 15));
                default: w = WGT_W'($urandom());
            endcase
            send_interval(first, stop, w, k == n_items - 1);
        end
    endtask

    initial begin
        aresetn = 1'b0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // ---- directed part, reset settings first (full line, threshold 1) ----
        // whole line at full weight: nothing quiet
        send_interval(1, 4096, 16'hFFFF, 1'b1);
        // zero start and an end far past the line, zero weight: everything quiet
        send_interval(0, 8191, 16'h0000, 1'b1);
        // start after end, start past the line, largest field values
        send_interval(5, 3, 100, 1'b0);
        send_interval(4097, 5000, 7, 1'b0);
        send_interval(8191, 8191, 16'hFFFF, 1'b1);

        // empty line
        settle_idle();
        write_reg(REG_LINE_LENGTH, 0);
        send_interval(1, 1, 1, 1'b1);

        // over-long line is clamped; threshold of zero counts nothing
        settle_idle();
        write_reg(REG_LINE_LENGTH, 24'hFF_FFFF);
        write_reg(REG_THRESHOLD, 0);
        send_interval(1, 10, 5, 1'b1);

        // largest threshold: every position below it
        settle_idle();
        write_reg(REG_LINE_LENGTH, 10);
        write_reg(REG_THRESHOLD, 24'hFF_FFFF);
        send_interval(1, 10, 16'hFFFF, 1'b0);
        send_interval(3, 7, 16'hFFFF, 1'b1);

        // threshold sitting just above one weight: overlap tips position 5 over
        settle_idle();
        write_reg(REG_THRESHOLD, 65536);
        send_interval(1, 5, 16'hFFFF, 1'b0);
        send_interval(5, 10, 1, 1'b0);
        send_interval(2, 20, 0, 1'b1);

        // single position, sum equal to threshold is not below it
        settle_idle();
        write_reg(REG_LINE_LENGTH, 1);
        write_reg(REG_THRESHOLD, 65535);
        send_interval(1, 1, 16'hFFFF, 1'b1);

        // line shortened inside an open set: the clipped end lies past the new line
        settle_idle();
        write_reg(REG_LINE_LENGTH, 20);
        write_reg(REG_THRESHOLD, 4);
        send_interval(15, 30, 9, 1'b0);
        settle_idle();
        write_reg(REG_LINE_LENGTH, 12);
        send_interval(1, 2, 3, 1'b1);

        // ---- random part ----
        while (items_sent < ITEM_TARGET) begin
            gaps_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 2) == 0) begin
                settle_idle();
                if ($urandom_range(0, 1) == 1)
                    write_reg(REG_LINE_LENGTH, random_line_length());
                else
                    write_reg(REG_THRESHOLD, random_threshold());
            end

            if (sets_sent == 25) begin
                // back-pressure: receiver holds off while three sets pile up
                settle_idle();
                gaps_on  = 1'b0;
                hold_req = 1'b1;
                repeat (3) send_set(4, 1'b0);
            end else if (sets_sent == 15) begin
                send_set(MAX_INTERVALS, 1'b0);                          // exactly full
            end else if (sets_sent == 40) begin
                send_set(MAX_INTERVALS + $urandom_range(1, 12), 1'b0);  // overflows
            end else begin
                send_set($urandom_range(1, 16), $urandom_range(0, 9) == 0);
            end
        end

        // ---- drain ----
        @(negedge aclk);
        s_tvalid = 1'b0;
        wait (pending == 0);
        repeat (TAIL_WAIT) @(negedge aclk);

        $display("Run covered %0d interval words in %0d sets with %0d register writes,",
                 items_sent, sets_sent, cfg_writes);
        $display("including a full set, an overflowing set and a long receiver hold-off.");
        if (fail_count == 0 && pending == 0)
            $display("tb_weighted_interval_coverage_count_unit OK");
        else
            $display("tb_weighted_interval_coverage_count_unit NOT OK");
        $finish;
    end

endmodule

>>> weighted_interval_coverage_count_unit.f
design/wicc_pkg.sv
design/wicc_ram.sv
design/wicc_addcmp.sv
design/weighted_interval_coverage_count_unit.sv
sim/wicc_quiet_count_checker.sv
sim/tb_weighted_interval_coverage_count_unit.sv
